// ----- sv/mmf_pkg.sv -----
package mmf_pkg;
   localparam int MaxItems = 64;
   localparam int IdxW = $clog2(MaxItems);
   localparam int CntW = 7;

   typedef struct packed {
      logic load;
      logic scan_start;
      logic scan_step;
      logic clear;
   } cmd_type;

   typedef struct packed {
      logic       scan_hit;
      logic       scan_last;
      logic       scan_done;
   } status_type;
endpackage

// ----- sv/mmf_datapath.sv -----
module mmf_datapath import mmf_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  cmd_type           cmd,
   input  logic [31:0]       req_sample_value,
   output status_type        status,
   output logic [31:0]       scan_value,
   output logic              overflow
);
   logic [31:0]     val_ff [MaxItems];
   logic [CntW-1:0] cnt_ff [MaxItems];
   logic [MaxItems-1:0] used_ff;
   logic [CntW-1:0] items_ff, high_ff;
   logic            ovf_ff;
   logic [IdxW:0]   ptr_ff;
   logic [MaxItems-1:0] less, equal;
   logic            found;
   logic [CntW-1:0] new_cnt;

   // per-cell compare against the incoming value
   always_comb begin
      found = 1'b0;
      new_cnt = '0;
      for (int i = 0; i < MaxItems; i++) begin
         less[i]  = used_ff[i] && ($signed(val_ff[i]) < $signed(req_sample_value));
         equal[i] = used_ff[i] && (val_ff[i] == req_sample_value);
         if (equal[i]) begin
            found = 1'b1;
            new_cnt = cnt_ff[i] + 1'b1;
         end
      end
      if (!found) new_cnt = CntW'(1);
   end

   // sorted chain of cells, shifted insert or count bump
   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         used_ff <= '0;
         items_ff <= '0;
         high_ff <= '0;
         ovf_ff <= 1'b0;
         for (int i = 0; i < MaxItems; i++) cnt_ff[i] <= '0;
      end else if (cmd.load) begin
         if (items_ff >= CntW'(MaxItems)) begin
            ovf_ff <= 1'b1;
         end else if (found || !used_ff[MaxItems-1]) begin
            items_ff <= items_ff + 1'b1;
            if (new_cnt > high_ff) high_ff <= new_cnt;
            for (int i = 0; i < MaxItems; i++) begin
               if (equal[i]) begin
                  cnt_ff[i] <= new_cnt;
               end else if (!found && !less[i]) begin
                  if (i == 0 || less[(i+MaxItems-1)%MaxItems] || !used_ff[i]) begin
                     if (i == 0 || used_ff[(i+MaxItems-1)%MaxItems]
                         || !used_ff[i]) begin
                        if (i == 0 || less[(i+MaxItems-1)%MaxItems]) begin
                           val_ff[i] <= req_sample_value;
                           cnt_ff[i] <= CntW'(1);
                           used_ff[i] <= 1'b1;
                        end else if (used_ff[(i+MaxItems-1)%MaxItems]) begin
                           val_ff[i] <= val_ff[(i+MaxItems-1)%MaxItems];
                           cnt_ff[i] <= cnt_ff[(i+MaxItems-1)%MaxItems];
                           used_ff[i] <= 1'b1;
                        end
                     end
                  end else begin
                     val_ff[i] <= val_ff[(i+MaxItems-1)%MaxItems];
                     cnt_ff[i] <= cnt_ff[(i+MaxItems-1)%MaxItems];
                  end
               end
            end
         end
      end
   end

   // scan pointer over the cells
   always_ff @(posedge clock) begin
      if (reset || cmd.scan_start) ptr_ff <= '0;
      else if (cmd.scan_step) ptr_ff <= ptr_ff + 1'b1;
   end

   logic [IdxW-1:0] idx;
   logic            later;
   assign idx = ptr_ff[IdxW-1:0];
   always_comb begin
      later = 1'b0;
      for (int i = 0; i < MaxItems; i++)
         if (i > idx && used_ff[i] && cnt_ff[i] == high_ff) later = 1'b1;
   end
   assign scan_value       = val_ff[idx];
   assign status.scan_done = ptr_ff[IdxW] || !used_ff[idx];
   assign status.scan_hit  = !status.scan_done && cnt_ff[idx] == high_ff;
   assign status.scan_last = !later;
   assign overflow = ovf_ff;
endmodule

// ----- sv/mmf_control.sv -----
module mmf_control import mmf_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_set_end,
   input  status_type status,
   input  logic       rsp_hold,
   output cmd_type    cmd
);
   typedef enum logic [1:0] {LOAD, START, SCAN, CLEAR} state_type;
   state_type state_ff;

   assign req_ready = (state_ff == LOAD);
   always_comb begin
      cmd = '0;
      cmd.load = req_valid && req_ready;
      cmd.scan_start = (state_ff == START);
      cmd.scan_step = (state_ff == SCAN) && !rsp_hold && !status.scan_done;
      cmd.clear = (state_ff == CLEAR);
   end

   // one set loads, then the cells are scanned out
   always_ff @(posedge clock) begin
      if (reset) state_ff <= LOAD;
      else begin
         unique case (state_ff)
            LOAD:  if (req_valid && req_set_end) state_ff <= START;
            START: state_ff <= SCAN;
            SCAN:  if (status.scan_done && !rsp_hold) state_ff <= CLEAR;
            CLEAR: state_ff <= LOAD;
            default: state_ff <= LOAD;
         endcase
      end
   end
endmodule

// ----- sv/multimodal_mode_finder_unit.sv -----
// Loads one value per cycle into a sorted chain of 64 value/count cells;
// after the set end item it scans the chain one cell per cycle while the
// response is not held, and emits every mode in ascending order,
// accepting no new item until the scan and the store clear are done.
module multimodal_mode_finder_unit import mmf_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_sample_value,
   input  logic        req_set_end,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_mode_value,
   output logic        rsp_final_mode,
   output logic        rsp_items_dropped
);
   cmd_type    cmd;
   status_type status;
   logic [31:0] scan_value;
   logic        overflow, hold;

   assign hold = rsp_valid && !rsp_ready;

   mmf_control u_ctl (.clock, .reset, .req_valid, .req_ready, .req_set_end,
      .status, .rsp_hold(hold), .cmd);
   mmf_datapath u_dp (.clock, .reset, .cmd, .req_sample_value, .status,
      .scan_value, .overflow);

   // output register
   always_ff @(posedge clock) begin
      if (reset) rsp_valid <= 1'b0;
      else if (!hold) rsp_valid <= cmd.scan_step && status.scan_hit;
      if (!hold) begin
         rsp_mode_value    <= scan_value;
         rsp_final_mode    <= status.scan_last;
         rsp_items_dropped <= overflow;
      end
   end
endmodule

// ----- sv/mmf_checker.sv -----
module mmf_checker (
   input logic clock, reset, req_valid, req_ready, rsp_valid, rsp_ready,
   input logic [31:0] rsp_mode_value, input logic rsp_final_mode
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_mode_value))
      else $error("rsp hold");
   a_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("overlap");
   a_fin: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_final_mode |=> !rsp_valid)
      else $error("after final");
endmodule

bind multimodal_mode_finder_unit mmf_checker u_chk (.*);
